// ===== hdl/rcsm_pkg.sv =====
package rcsm_pkg;

  localparam int PWM_W            = 12;
  localparam int STICK_W          = 16;
  localparam int NUM_STICKS       = 4;
  localparam int STICK_CHANNELS_DEF = 4;
  localparam int CFG_ADDR_W       = 3;

  // stick scaling
  localparam int CENTER_US   = 1500;
  localparam int HALF_SPAN   = 500;
  localparam int Q12_SHIFT   = 12;
  localparam int QUO_W       = 16;
  localparam int BAR_W       = 21;                      // 500 * 4096 fits
  localparam int LHS_W       = PWM_W + Q12_SHIFT;       // magnitude in Q12
  localparam int REM_W       = LHS_W + Q12_SHIFT;       // dividend width
  localparam int STEP_CNT_W  = 4;                       // counts QUO_W steps

  localparam logic [PWM_W-1:0] VALID_LOW  = PWM_W'(900);
  localparam logic [PWM_W-1:0] VALID_HIGH = PWM_W'(2100);

  localparam logic [STICK_W-1:0] STICK_POS_MAX = 16'h7fff;
  localparam logic [STICK_W-1:0] STICK_NEG_MAX = 16'h8000;

  // config reset values
  localparam logic [PWM_W-1:0] DEADBAND_RST  = PWM_W'(205);
  localparam logic [PWM_W-1:0] ARM_THR_RST   = PWM_W'(1750);
  localparam logic [PWM_W-1:0] MODE_THR_RST  = PWM_W'(1750);
  localparam logic [PWM_W-1:0] GEAR_UP_RST   = PWM_W'(1750);
  localparam logic [PWM_W-1:0] GEAR_DN_RST   = PWM_W'(1250);

  // packed word layout
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 72;
  localparam int FLAG_BASE  = NUM_STICKS * STICK_W;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_DEADBAND  = 3'd0,
    REG_ARM_THR   = 3'd1,
    REG_MODE_THR  = 3'd2,
    REG_GEAR_UP   = 3'd3,
    REG_GEAR_DN   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic [PWM_W-1:0] arm_thr;
    logic [PWM_W-1:0] mode_thr;
    logic [PWM_W-1:0] gear_up_thr;
    logic [PWM_W-1:0] gear_dn_thr;
  } sw_cfg_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
  } lane_ctrl_t;

  // listed msb first; packs lsb up as frame_valid..armed reversed
  typedef struct packed {
    logic frame_valid;
    logic hold_mode;
    logic command_mode;
    logic command_requested;
    logic hover_requested;
    logic offboard;
    logic armed;
  } sw_flags_t;

endpackage

// ===== hdl/rc_frame_stick_and_mode_decoder.sv =====
// Decodes one radio-control frame of seven pulse widths per word. Each stick
// channel is centered at 1500 us, scaled by 1/500, passed through the dead zone
// and rescaled by 1/(1-deadband) into saturated Q3.12; the arm, mode and gear
// switches are compared against their thresholds and mode/gear edges latch the
// hover and command request flags. The stick channels run in parallel lanes,
// each with its own restoring divider that retires one quotient bit a cycle;
// a word passes a setup step, 16 divider steps and a merge into the output
// register, and no new word is taken before the lanes are done with the last.
// A new input word is taken as soon as the lanes are free, even while the
// previous result still waits in the output register; a stalled output keeps
// the next finished word in the lanes and the input closed. Configuration
// writes take effect for the next word; write only while the block is idle.
module rc_frame_stick_and_mode_decoder #(
  parameter int STICK_CHANNELS = rcsm_pkg::STICK_CHANNELS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // in_tdata lsb up: pwm_roll, pwm_pitch, pwm_throttle, pwm_yaw, pwm_arm,
  // pwm_mode, pwm_gear (12 bits each), zero pad
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rcsm_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata lsb up: stick_roll, stick_pitch, stick_throttle, stick_yaw
  // (16 bits each), armed, offboard, hover_requested, command_requested,
  // command_mode, hold_mode, frame_valid, zero pad
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [rcsm_pkg::OUT_DATA_W-1:0]      out_tdata,
  // configuration write port
  input  logic                                 cfg_wr_en,
  input  logic [rcsm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rcsm_pkg::PWM_W-1:0]           cfg_wdata
);
  import rcsm_pkg::*;

  // lanes actually built; outputs beyond them read zero
  localparam int LANES = (STICK_CHANNELS < NUM_STICKS) ? STICK_CHANNELS : NUM_STICKS;

  // configuration registers
  logic [PWM_W-1:0] deadband_r;
  sw_cfg_t          sw_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r           <= DEADBAND_RST;
      sw_cfg_r.arm_thr     <= ARM_THR_RST;
      sw_cfg_r.mode_thr    <= MODE_THR_RST;
      sw_cfg_r.gear_up_thr <= GEAR_UP_RST;
      sw_cfg_r.gear_dn_thr <= GEAR_DN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DEADBAND:  deadband_r           <= cfg_wdata;
        REG_ARM_THR:   sw_cfg_r.arm_thr     <= cfg_wdata;
        REG_MODE_THR:  sw_cfg_r.mode_thr    <= cfg_wdata;
        REG_GEAR_UP:   sw_cfg_r.gear_up_thr <= cfg_wdata;
        REG_GEAR_DN:   sw_cfg_r.gear_dn_thr <= cfg_wdata;
        default: ;     // unmapped index, write dropped
      endcase
    end
  end

  // dead zone threshold 500*z and divisor 500*(4096-z), shared by all lanes;
  // refreshed every cycle so they settle before the setup cycle reads them
  logic [BAR_W-1:0] bar_r;
  logic [BAR_W-1:0] div_r;

  always_ff @(posedge clk) begin
    bar_r <= BAR_W'(deadband_r) * BAR_W'(HALF_SPAN);
    div_r <= BAR_W'((PWM_W+1)'(1 << Q12_SHIFT) - (PWM_W+1)'(deadband_r)) * BAR_W'(HALF_SPAN);
  end

  // sequencer
  seq_state_t            state_r, state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r,   cnt_nxt;
  lane_ctrl_t            lane_ctrl;
  logic                  in_fire;
  logic                  finish;
  logic                  out_free;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_tvalid || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    in_tready      = 1'b0;
    finish         = 1'b0;
    lane_ctrl.load = 1'b0;
    lane_ctrl.prep = 1'b0;
    lane_ctrl.step = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready      = 1'b1;
        lane_ctrl.load = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        lane_ctrl.prep = 1'b1;
        cnt_nxt        = '0;
        state_nxt      = ST_DIV;
      end
      ST_DIV: begin
        lane_ctrl.step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(QUO_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold here until the output register can take the result
        if (out_free) begin
          finish    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // switch channels captured with the word
  logic [PWM_W-1:0] arm_r, mode_r, gear_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      arm_r  <= in_tdata[4*PWM_W +: PWM_W];
      mode_r <= in_tdata[5*PWM_W +: PWM_W];
      gear_r <= in_tdata[6*PWM_W +: PWM_W];
    end
  end

  // stick lanes
  logic signed [STICK_W-1:0] stick [NUM_STICKS];

  for (genvar g = 0; g < NUM_STICKS; g++) begin : g_lane
    if (g < LANES) begin : g_on
      rcsm_lane u_lane (
        .clk     (clk),
        .ctrl    (lane_ctrl),
        .pwm     (in_tdata[g*PWM_W +: PWM_W]),
        .bar     (bar_r),
        .divisor (div_r),
        .stick   (stick[g])
      );
    end else begin : g_off
      assign stick[g] = '0;
    end
  end

  // switch and mode flags, state advances when the result is merged
  sw_flags_t flags;

  rcsm_switch u_switch (
    .clk    (clk),
    .rst_n  (rst_n),
    .update (finish),
    .cfg    (sw_cfg_r),
    .arm    (arm_r),
    .mode   (mode_r),
    .gear   (gear_r),
    .flags  (flags)
  );

  // merge into the output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < NUM_STICKS; i++) begin
      out_data_nxt[i*STICK_W +: STICK_W] = stick[i];
    end
    out_data_nxt[FLAG_BASE + 0] = flags.armed;
    out_data_nxt[FLAG_BASE + 1] = flags.offboard;
    out_data_nxt[FLAG_BASE + 2] = flags.hover_requested;
    out_data_nxt[FLAG_BASE + 3] = flags.command_requested;
    out_data_nxt[FLAG_BASE + 4] = flags.command_mode;
    out_data_nxt[FLAG_BASE + 5] = flags.hold_mode;
    out_data_nxt[FLAG_BASE + 6] = flags.frame_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/rcsm_lane.sv =====
module rcsm_lane (
  input  logic                              clk,
  input  rcsm_pkg::lane_ctrl_t              ctrl,
  input  logic [rcsm_pkg::PWM_W-1:0]        pwm,
  input  logic [rcsm_pkg::BAR_W-1:0]        bar,
  input  logic [rcsm_pkg::BAR_W-1:0]        divisor,
  output logic signed [rcsm_pkg::STICK_W-1:0] stick
);
  import rcsm_pkg::*;

  logic                neg_r,  neg_nxt;
  logic [PWM_W-1:0]    mag_r,  mag_nxt;
  logic                zero_r, zero_nxt;
  logic                ovf_r,  ovf_nxt;
  logic [REM_W-1:0]    rem_r,  rem_nxt;
  logic [REM_W-1:0]    dsh_r,  dsh_nxt;
  logic [QUO_W-1:0]    quo_r,  quo_nxt;

  logic [PWM_W:0]      diff_s;
  logic [LHS_W-1:0]    lhs;
  logic [LHS_W-1:0]    excess;

  assign diff_s = {1'b0, pwm} - (PWM_W+1)'(CENTER_US);
  assign lhs    = {mag_r, {Q12_SHIFT{1'b0}}};
  assign excess = lhs - LHS_W'(bar);

  always_comb begin
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    zero_nxt = zero_r;
    ovf_nxt  = ovf_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quo_nxt  = quo_r;
    if (ctrl.load) begin
      neg_nxt = diff_s[PWM_W];
      mag_nxt = diff_s[PWM_W] ? PWM_W'(-diff_s) : diff_s[PWM_W-1:0];
    end else if (ctrl.prep) begin
      zero_nxt = (lhs <= LHS_W'(bar));
      // quotient reaches 2^16 exactly when excess >= divisor * 16
      ovf_nxt  = ({1'b0, excess} >= {divisor, 4'b0000});
      rem_nxt  = {excess, {Q12_SHIFT{1'b0}}};
      dsh_nxt  = REM_W'({divisor, {(QUO_W-1){1'b0}}});
      quo_nxt  = '0;
    end else if (ctrl.step) begin
      if (rem_r >= dsh_r) begin
        rem_nxt = rem_r - dsh_r;
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      dsh_nxt = dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    zero_r <= zero_nxt;
    ovf_r  <= ovf_nxt;
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quo_r  <= quo_nxt;
  end

  // sign and saturate
  always_comb begin
    if (zero_r) begin
      stick = '0;
    end else if (neg_r) begin
      if (ovf_r || quo_r > STICK_NEG_MAX) begin
        stick = STICK_NEG_MAX;
      end else begin
        stick = STICK_W'(16'd0 - quo_r);
      end
    end else begin
      if (ovf_r || quo_r > STICK_POS_MAX) begin
        stick = STICK_POS_MAX;
      end else begin
        stick = quo_r;
      end
    end
  end

endmodule

// ===== hdl/rcsm_switch.sv =====
module rcsm_switch (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       update,
  input  rcsm_pkg::sw_cfg_t          cfg,
  input  logic [rcsm_pkg::PWM_W-1:0] arm,
  input  logic [rcsm_pkg::PWM_W-1:0] mode,
  input  logic [rcsm_pkg::PWM_W-1:0] gear,
  output rcsm_pkg::sw_flags_t        flags
);
  import rcsm_pkg::*;

  logic [PWM_W-1:0] prev_mode_r, prev_mode_nxt;
  logic [PWM_W-1:0] prev_gear_r, prev_gear_nxt;
  logic             seen_r;
  logic             hover_r,    hover_nxt;
  logic             cmd_req_r,  cmd_req_nxt;
  logic             cmd_mode_r, cmd_mode_nxt;
  logic             hold_r,     hold_nxt;

  logic [PWM_W-1:0] pm, pg;
  logic             offboard;

  // first frame compares against itself, so it makes no edge
  assign pm       = seen_r ? prev_mode_r : mode;
  assign pg       = seen_r ? prev_gear_r : gear;
  assign offboard = mode > cfg.mode_thr;

  always_comb begin
    hover_nxt    = hover_r;
    cmd_req_nxt  = cmd_req_r;
    cmd_mode_nxt = 1'b0;
    hold_nxt     = hold_r;
    prev_mode_nxt = mode;
    prev_gear_nxt = gear;

    if (pm < cfg.mode_thr && mode > cfg.mode_thr) begin
      hover_nxt = 1'b1;
    end else if (pm > cfg.mode_thr && mode < cfg.mode_thr) begin
      hover_nxt = 1'b0;
    end

    if (offboard) begin
      if (pg < cfg.gear_up_thr && gear > cfg.gear_up_thr) begin
        cmd_req_nxt = 1'b1;
      end else if (pg > cfg.gear_up_thr && gear < cfg.gear_up_thr) begin
        cmd_req_nxt = 1'b0;
      end
      if (gear > cfg.gear_up_thr) begin
        cmd_mode_nxt = 1'b1;
        hold_nxt     = 1'b0;
      end else if (gear > cfg.gear_dn_thr && gear < cfg.gear_up_thr) begin
        hold_nxt = 1'b1;
      end else begin
        hold_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= 1'b0;
      hover_r    <= 1'b0;
      cmd_req_r  <= 1'b0;
      cmd_mode_r <= 1'b1;
      hold_r     <= 1'b0;
    end else if (update) begin
      seen_r     <= 1'b1;
      hover_r    <= hover_nxt;
      cmd_req_r  <= cmd_req_nxt;
      cmd_mode_r <= cmd_mode_nxt;
      hold_r     <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      prev_mode_r <= prev_mode_nxt;
      prev_gear_r <= prev_gear_nxt;
    end
  end

  always_comb begin
    flags.armed             = arm > cfg.arm_thr;
    flags.offboard          = offboard;
    flags.hover_requested   = hover_nxt;
    flags.command_requested = cmd_req_nxt;
    flags.command_mode      = update ? cmd_mode_nxt : cmd_mode_r;
    flags.hold_mode         = hold_nxt;
    flags.frame_valid       = mode >= VALID_LOW && mode <= VALID_HIGH &&
                              gear >= VALID_LOW && gear <= VALID_HIGH;
  end

endmodule

// ===== hdl/rcsm_checker.sv =====
module rcsm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rcsm_pkg::OUT_DATA_W-1:0] out_tdata
);
  import rcsm_pkg::*;

  // a held result keeps its word
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one word in flight: lanes are busy right after a word is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while lanes busy");

  // command and hold modes exclude each other
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[FLAG_BASE + 4] && out_tdata[FLAG_BASE + 5]))
    else $error("command and hold mode both set");

  // command mode needs offboard
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[FLAG_BASE + 4] |-> out_tdata[FLAG_BASE + 1])
    else $error("command mode without offboard");

endmodule

bind rc_frame_stick_and_mode_decoder rcsm_checker u_rcsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rcsm_pkg::*;

  localparam int ACTIVE_STICKS = STICK_CHANNELS_DEF;
  localparam int NUM_REGS      = 5;
  localparam int NUM_ADDRS     = 1 << CFG_ADDR_W;
  localparam int NUM_FIELDS    = NUM_STICKS + 7;
  localparam int PWM_MAX       = (1 << PWM_W) - 1;
  localparam int NUM_PHASES    = 8;
  localparam int TAIL_CYCLES   = 40;
  localparam int PRESSURE_HOLD = 400;
  localparam int MAX_REPORTS   = 60;

  // one rc frame, roll in the lowest bits as on in_tdata
  typedef struct packed {
    logic [PWM_W-1:0] gear, mode, arm, yaw, throttle, pitch, roll;
  } rc_frame_t;

  // decoder state mirror, predicts one output word per accepted frame
  class decode_tracker;
    logic [PWM_W-1:0] deadband  = DEADBAND_RST;
    logic [PWM_W-1:0] arm_thr   = ARM_THR_RST;
    logic [PWM_W-1:0] mode_thr  = MODE_THR_RST;
    logic [PWM_W-1:0] gear_up   = GEAR_UP_RST;
    logic [PWM_W-1:0] gear_dn   = GEAR_DN_RST;
    logic [PWM_W-1:0] prev_mode = '0;
    logic [PWM_W-1:0] prev_gear = '0;
    bit seeded   = 1'b0;
    bit hover    = 1'b0;
    bit cmd_req  = 1'b0;
    bit cmd_mode = 1'b1;
    bit hold     = 1'b0;
    logic [OUT_DATA_W-1:0] pending_decodes[$];
    int n_frames = 0;
    int n_checked = 0;
    int n_errors = 0;
    int hover_latches = 0;
    int command_latches = 0;

    function void set_reg(logic [CFG_ADDR_W-1:0] addr, logic [PWM_W-1:0] value);
      case (addr)
        REG_DEADBAND:  deadband  = value;
        REG_ARM_THR:   arm_thr   = value;
        REG_MODE_THR:  mode_thr  = value;
        REG_GEAR_UP:   gear_up   = value;
        REG_GEAR_DN:   gear_dn   = value;
        default: ;
      endcase
    endfunction

    // centered, dead-zoned and rescaled stick in saturated q3.12
    function logic [STICK_W-1:0] stick_q12(logic [PWM_W-1:0] pwm);
      longint unsigned mag, lhs, bar, q, dz;
      bit neg;
      dz  = deadband;
      neg = pwm < CENTER_US;
      mag = neg ? longint'(CENTER_US - int'(pwm)) : longint'(int'(pwm) - CENTER_US);
      lhs = mag << Q12_SHIFT;
      bar = HALF_SPAN * dz;
      if (lhs <= bar) return '0;
      q = ((lhs - bar) << Q12_SHIFT) / (HALF_SPAN * ((64'd1 << Q12_SHIFT) - dz));
      if (neg) begin
        if (q > 64'd32768) q = 64'd32768;
        return STICK_W'(64'd65536 - q);
      end
      if (q > 64'd32767) q = 64'd32767;
      return STICK_W'(q);
    endfunction

    function void accept_frame(rc_frame_t f);
      logic [OUT_DATA_W-1:0] w;
      logic [PWM_W-1:0] ch [NUM_STICKS];
      bit armed, offb, valid;
      int i;
      ch = '{f.roll, f.pitch, f.throttle, f.yaw};
      w = '0;
      for (i = 0; i < NUM_STICKS; i++)
        if (i < ACTIVE_STICKS) w[STICK_W*i +: STICK_W] = stick_q12(ch[i]);
      valid = f.mode >= VALID_LOW && f.mode <= VALID_HIGH &&
              f.gear >= VALID_LOW && f.gear <= VALID_HIGH;
      // first frame seeds the edge history so it never makes an edge
      if (!seeded) begin
        seeded    = 1'b1;
        prev_mode = f.mode;
        prev_gear = f.gear;
      end
      armed = f.arm > arm_thr;
      if (prev_mode < mode_thr && f.mode > mode_thr) begin
        if (!hover) hover_latches++;
        hover = 1'b1;
      end else if (prev_mode > mode_thr && f.mode < mode_thr) begin
        hover = 1'b0;
      end
      offb = f.mode > mode_thr;
      if (offb) begin
        if (prev_gear < gear_up && f.gear > gear_up) begin
          if (!cmd_req) command_latches++;
          cmd_req = 1'b1;
        end else if (prev_gear > gear_up && f.gear < gear_up) begin
          cmd_req = 1'b0;
        end
        if (f.gear > gear_up) begin
          cmd_mode = 1'b1;
          hold     = 1'b0;
        end else if (f.gear > gear_dn && f.gear < gear_up) begin
          cmd_mode = 1'b0;
          hold     = 1'b1;
        end else begin
          cmd_mode = 1'b0;
          hold     = 1'b0;
        end
      end else begin
        cmd_mode = 1'b0;
      end
      prev_mode = f.mode;
      prev_gear = f.gear;
      w[FLAG_BASE +: 7] = {valid, hold, cmd_mode, cmd_req, hover, offb, armed};
      pending_decodes.push_back(w);
      n_frames++;
    endfunction

    function logic [STICK_W-1:0] field_of(logic [OUT_DATA_W-1:0] w, int k);
      if (k < NUM_STICKS) return w[STICK_W*k +: STICK_W];
      return STICK_W'(w[FLAG_BASE + k - NUM_STICKS]);
    endfunction

    function string field_name(int k);
      case (k)
        0: return "stick_roll";
        1: return "stick_pitch";
        2: return "stick_throttle";
        3: return "stick_yaw";
        4: return "armed";
        5: return "offboard";
        6: return "hover_requested";
        7: return "command_requested";
        8: return "command_mode";
        9: return "hold_mode";
        default: return "frame_valid";
      endcase
    endfunction

    function void check_decode(logic [OUT_DATA_W-1:0] got);
      logic [OUT_DATA_W-1:0] want;
      int k;
      if (pending_decodes.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t ns: unexpected word, expected none got %h", $time, got);
        return;
      end
      want = pending_decodes.pop_front();
      n_checked++;
      for (k = 0; k < NUM_FIELDS; k++) begin
        if (field_of(want, k) !== field_of(got, k)) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t ns: word %0d %s expected %h got %h", $time, n_checked,
                     field_name(k), field_of(want, k), field_of(got, k));
        end
      end
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
  logic [PWM_W-1:0]       cfg_wdata = '0;

  decode_tracker sb = new();

  bit steady = 1'b0;           // no random idling on either side while set
  int hold_off_request = 0;    // long receiver hold-off, picked up by the sink

  // directed frames: roll, pitch, throttle, yaw, arm, mode, gear
  int directed_rows [23][7] = '{
    '{1500, 1500, 1500, 1500,    0, 2000, 2000},   // first frame above both thresholds
    '{   0, 4095, 1525, 1526, 1750, 1500, 1500},   // stick extremes, dead zone edge
    '{1474, 1475, 1000, 2000, 1751, 2000, 1500},   // mode rises, gear in hold band
    '{4095,    0, 2000, 1000, 4095, 2000, 2000},   // gear rises into command
    '{1526, 1474, 1500, 1500, 1749, 2000, 1750},   // gear on up threshold
    '{1501, 1499, 2100,  900, 1500, 2000, 1000},   // no falling edge from threshold
    '{1500, 1500, 1500, 1500, 1500, 2000, 1250},   // gear on down threshold
    '{1500, 1500, 1500, 1500, 1500, 2000, 1251},
    '{1500, 1500, 1500, 1500, 1500, 2000, 1749},
    '{1500, 1500, 1500, 1500, 1500, 2000, 2100},
    '{1500, 1500, 1500, 1500, 1500, 2000, 1000},   // gear falls, command cleared
    '{1500, 1500, 1500, 1500, 1500, 2000, 1500},
    '{1500, 1500, 1500, 1500, 1500, 1750, 2000},   // mode on threshold, hold kept
    '{1500, 1500, 1500, 1500, 1500, 1000, 1000},
    '{1500, 1500, 1500, 1500, 1500, 2000, 1000},
    '{1500, 1500, 1500, 1500, 1500, 1000, 1000},   // mode falls, hover cleared
    '{   1, 2999, 3000, 4094, 1500,  899,  900},   // valid window edges
    '{1500, 1500, 1500, 1500, 1500,  900,  899},
    '{1500, 1500, 1500, 1500, 1500, 2100, 2101},
    '{1500, 1500, 1500, 1500, 1500, 2101, 2100},
    '{   0,    0,    0,    0,    0,    0,    0},
    '{4095, 4095, 4095, 4095, 4095, 4095, 4095},
    '{1500, 1500, 1500, 1500, 1751, 1500, 2000}    // gear ignored while not offboard
  };

  rc_frame_stick_and_mode_decoder #(
    .STICK_CHANNELS(ACTIVE_STICKS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),     // lsb up: roll, pitch, throttle, yaw, arm, mode, gear
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),    // lsb up: four sticks, armed .. frame_valid
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PWM_W-1:0] clamp_pwm(int v);
    if (v < 0) return '0;
    if (v > PWM_MAX) return PWM_W'(PWM_MAX);
    return PWM_W'(v);
  endfunction

  // switch level clustered around a threshold and the valid window
  function automatic logic [PWM_W-1:0] near_level(logic [PWM_W-1:0] thr);
    int t, v;
    t = thr;
    case ($urandom_range(0, 7))
      0: v = t;
      1: v = t - 1;
      2: v = t + 1;
      3: v = t - int'($urandom_range(2, 400));
      4: v = t + int'($urandom_range(2, 400));
      5: v = $urandom_range(0, 1) ? int'(VALID_LOW) - int'($urandom_range(0, 1))
                                  : int'(VALID_HIGH) + int'($urandom_range(0, 1));
      default: v = $urandom_range(800, 2200);
    endcase
    return clamp_pwm(v);
  endfunction

  function automatic logic [PWM_W-1:0] stick_pwm();
    int bound_us, v;
    // largest offset still inside the dead zone
    bound_us = (HALF_SPAN * int'(sb.deadband)) >>> Q12_SHIFT;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, PWM_MAX);
      1: v = CENTER_US + ($urandom_range(0, 1) ? 1 : -1) *
                         (bound_us + int'($urandom_range(0, 1)));
      2: v = $urandom_range(1000, 2000);
      default: v = CENTER_US + int'($urandom_range(0, 1200)) - 600;
    endcase
    return clamp_pwm(v);
  endfunction

  function automatic rc_frame_t random_frame();
    rc_frame_t f;
    f.roll     = stick_pwm();
    f.pitch    = stick_pwm();
    f.throttle = stick_pwm();
    f.yaw      = stick_pwm();
    if ($urandom_range(0, 4) == 0) begin
      // noise on the switches
      f.arm  = PWM_W'($urandom);
      f.mode = PWM_W'($urandom);
      f.gear = PWM_W'($urandom);
    end else begin
      f.arm  = near_level(sb.arm_thr);
      f.mode = near_level(sb.mode_thr);
      f.gear = $urandom_range(0, 1) ? near_level(sb.gear_up) : near_level(sb.gear_dn);
    end
    return f;
  endfunction

  // offer one frame after a random gap, hold it until accepted
  task automatic offer_frame(rc_frame_t f);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(f);
    do @(posedge clk); while (!in_tready);
    sb.accept_frame(f);
  endtask

  // stop offering and wait until every predicted word came back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending_decodes.size() != 0);
  endtask

  // unused addresses first (must be ignored), then the five real registers
  task automatic program_phase(int p);
    int v [NUM_REGS];
    int k, up;
    case (p)
      1: v = '{0, 0, 0, 0, 0};                              // all low extremes
      2: v = '{4000, PWM_MAX, PWM_MAX, PWM_MAX, PWM_MAX};   // all high extremes
      3: begin
        up = $urandom_range(1500, 1900);
        v = '{$urandom_range(0, 4000), $urandom_range(1000, 2000),
              $urandom_range(1200, 1900), up, $urandom_range(1100, up - 1)};
      end
      4: begin
        // down threshold above up threshold: no hold band
        up = $urandom_range(1200, 1500);
        v = '{$urandom_range(0, 4000), $urandom_range(1000, 2000),
              $urandom_range(1200, 1900), up, $urandom_range(up + 1, 1900)};
      end
      5: begin
        up = $urandom_range(1300, 1800);
        v = '{$urandom_range(0, 4000), $urandom_range(1000, 2000),
              $urandom_range(1200, 1900), up, up};
      end
      6: v = '{$urandom_range(0, 4000), $urandom_range(0, PWM_MAX),
               $urandom_range(0, PWM_MAX), $urandom_range(0, PWM_MAX),
               $urandom_range(0, PWM_MAX)};
      default: v = '{DEADBAND_RST, ARM_THR_RST, MODE_THR_RST, GEAR_UP_RST, GEAR_DN_RST};
    endcase
    for (k = NUM_REGS; k < NUM_ADDRS; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(k);
      cfg_wdata <= PWM_W'($urandom);
      @(posedge clk);
    end
    for (k = 0; k < NUM_REGS; k++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(k);
      cfg_wdata <= PWM_W'(v[k]);
      @(posedge clk);
      sb.set_reg(CFG_ADDR_W'(k), PWM_W'(v[k]));
    end
    cfg_wr_en <= 1'b0;
  endtask

  // result sink: checks accepted words, stalls at random, honors a long hold-off
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_decode(out_tdata);
      if (hold_off_request > 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end else if (stall == 0 && out_tready) begin
        stall = idle_cycles();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rc_frame_t f;
    int i, p;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: directed frames, then random ones
    for (i = 0; i < $size(directed_rows); i++) begin
      f.roll     = PWM_W'(directed_rows[i][0]);
      f.pitch    = PWM_W'(directed_rows[i][1]);
      f.throttle = PWM_W'(directed_rows[i][2]);
      f.yaw      = PWM_W'(directed_rows[i][3]);
      f.arm      = PWM_W'(directed_rows[i][4]);
      f.mode     = PWM_W'(directed_rows[i][5]);
      f.gear     = PWM_W'(directed_rows[i][6]);
      offer_frame(f);
    end
    for (i = 0; i < 150; i++) offer_frame(random_frame());

    // new settings only once the block has gone idle
    for (p = 1; p < NUM_PHASES; p++) begin
      drain_results();
      program_phase(p);
      if (p == NUM_PHASES - 1) begin
        // back to back traffic with the output blocked for a while
        steady = 1'b1;
        hold_off_request = PRESSURE_HOLD;
      end
      for (i = 0; i < 175; i++) offer_frame(random_frame());
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d frames under %0d register settings, %0d words checked",
             sb.n_frames, NUM_PHASES, sb.n_checked);
    $display("hover latched %0d times, command latched %0d times, %0d mismatches",
             sb.hover_latches, sb.command_latches, sb.n_errors);
    if (sb.n_errors == 0 && sb.pending_decodes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d words outstanding", sb.pending_decodes.size());
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/rcsm_pkg.sv
hdl/rcsm_lane.sv
hdl/rcsm_switch.sv
hdl/rc_frame_stick_and_mode_decoder.sv
hdl/rcsm_checker.sv
tb/tb_top.sv
